// ===== rtl/bfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Types, constants and word helpers for the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int MAX_FRAMES  = 32768;
    localparam int WORD_BITS   = 32;
    localparam int FRAME_BYTES = 4096;

    localparam int MAP_WORDS   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
    localparam int FRAME_IDX_W = WORD_IDX_W + BIT_IDX_W;
    localparam int POP_W       = BIT_IDX_W + 1;

    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 32;
    localparam int COUNT_W = 16;
    localparam int STAT_W  = 3;
    localparam int FUNC_W  = 2;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MARK_USED = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_MARK_FREE = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK          = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NO_FREE     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_MISALIGNED  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE       = 3'd3;
    localparam logic [STAT_W-1:0] STAT_DOUBLE_FREE = 3'd4;

    localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = COUNT_W'(32768);

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] start_address;
        logic [LEN_W-1:0]  region_length;
    } bfa_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  frame_address;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] free_total;
    } bfa_rsp_t;

    typedef logic [WORD_BITS-1:0] map_word_t;

    function automatic map_word_t range_mask(input logic [BIT_IDX_W-1:0] lo,
                                             input logic [BIT_IDX_W-1:0] hi);
        map_word_t ones;
        logic [BIT_IDX_W-1:0] top;
        ones = '1;
        top  = BIT_IDX_W'(WORD_BITS - 1);
        return (ones << lo) & (ones >> (top - hi));
    endfunction

    function automatic logic [BIT_IDX_W-1:0] lowest_one(input map_word_t v);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [POP_W-1:0] pop_count(input map_word_t v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bfa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire                      re,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bitmap_frame_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Used-bit map of physical frames in one RAM, with a free frame count.
// Allocate walks map words until a free bit is found and release visits one
// word; region marks walk every word of the region, then pass a settle state
// before the response.
// Throughput: one request at a time; the map RAM read port sets the walk
// rate at one word per cycle. Failed checks and empty regions skip the walk
// and go straight to the done state.
// Reset: a clear pass fills all 1024 map words with used bits before the first
// request is taken; free count resets to zero, frame_count to 32768.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cfg_write,
    input  wire  [bfa_pkg::COUNT_W-1:0] cfg_data,
    input  wire                        in_valid,
    output logic                       in_stall,
    input  wire  bfa_pkg::bfa_req_t    in_req,
    output logic                       out_valid,
    input  wire                        out_stall,
    output bfa_pkg::bfa_rsp_t          out_rsp
);

    import bfa_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_WALK   = 3'd2;
    localparam logic [2:0] ST_SETTLE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam int END_W  = ADDR_W + 2;
    localparam int LAST_W = END_W - FRAME_SHIFT;
    localparam int FREL_W = ADDR_W - FRAME_SHIFT;

    logic [2:0]             state_reg, state_next;
    logic [COUNT_W-1:0]     frame_count_reg;
    logic [COUNT_W-1:0]     free_reg, free_next;
    logic [WORD_IDX_W-1:0]  clr_cnt_reg;
    logic [FUNC_W-1:0]      op_reg, op_next;
    logic [FRAME_IDX_W-1:0] first_reg, first_next;
    logic [FRAME_IDX_W-1:0] lastm1_reg, lastm1_next;
    logic [WORD_IDX_W-1:0]  issue_word_reg, issue_word_next;
    logic                   issue_more_reg, issue_more_next;
    logic                   dv_reg;
    logic [WORD_IDX_W-1:0]  data_word_reg;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   pend_used_reg, pend_used_next;
    logic [POP_W-1:0]       pend_n_reg, pend_n_next;
    logic [STAT_W-1:0]      status_reg, status_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic                   out_valid_reg, out_valid_next;
    bfa_rsp_t               out_rsp_reg, out_rsp_next;
    logic                   out_load;

    logic                   ram_we;
    logic [WORD_IDX_W-1:0]  ram_waddr;
    map_word_t              ram_wdata;
    logic                   ram_re;
    map_word_t              ram_rdata;

    logic [COUNT_W-1:0]     lim;
    logic [FREL_W-1:0]      f_rel;
    logic [END_W-1:0]       end_sum;
    logic [LAST_W-1:0]      last_raw;
    logic [COUNT_W-1:0]     last_c;
    logic                   accept;

    logic [WORD_IDX_W-1:0]  last_word;
    logic [BIT_IDX_W-1:0]   mask_lo, mask_hi;
    map_word_t              mask, cand;
    logic                   is_last;
    logic [COUNT_W:0]       free_sum;

    assign lim = (frame_count_reg > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES)
                                                        : frame_count_reg;
    assign f_rel    = in_req.start_address[ADDR_W-1:FRAME_SHIFT];
    assign end_sum  = END_W'(in_req.start_address) + END_W'(in_req.region_length)
                    + END_W'(FRAME_BYTES - 1);
    assign last_raw = end_sum[END_W-1:FRAME_SHIFT];
    assign last_c   = (last_raw > LAST_W'(lim)) ? lim : last_raw[COUNT_W-1:0];
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    assign last_word = lastm1_reg[FRAME_IDX_W-1:BIT_IDX_W];
    assign is_last   = (data_word_reg == last_word);
    assign mask_lo   = (data_word_reg == first_reg[FRAME_IDX_W-1:BIT_IDX_W])
                     ? first_reg[BIT_IDX_W-1:0] : '0;
    assign mask_hi   = is_last ? lastm1_reg[BIT_IDX_W-1:0] : '1;
    assign mask      = range_mask(mask_lo, mask_hi);
    assign cand      = ~ram_rdata & mask;
    assign free_sum  = (COUNT_W + 1)'(free_reg) + (COUNT_W + 1)'(pend_n_reg);

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next      = state_reg;
        free_next       = free_reg;
        op_next         = op_reg;
        first_next      = first_reg;
        lastm1_next     = lastm1_reg;
        issue_word_next = issue_word_reg;
        issue_more_next = issue_more_reg;
        pend_valid_next = 1'b0;
        pend_used_next  = pend_used_reg;
        pend_n_next     = pend_n_reg;
        status_next     = status_reg;
        addr_next       = addr_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_rsp_next    = out_rsp_reg;
        ram_we          = 1'b0;
        ram_waddr       = data_word_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;

        // apply region count change from the previous word
        if (pend_valid_reg)
        begin
            if (pend_used_reg)
            begin
                free_next = (free_reg > COUNT_W'(pend_n_reg))
                          ? free_reg - COUNT_W'(pend_n_reg) : '0;
            end
            else
            begin
                free_next = free_sum[COUNT_W] ? '1 : free_sum[COUNT_W-1:0];
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '1;
                if (clr_cnt_reg == WORD_IDX_W'(MAP_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = in_req.func;
                    status_next = STAT_OK;
                    addr_next   = '0;
                    state_next  = ST_DONE;
                    case (in_req.func)
                        FUNC_ALLOC:
                        begin
                            if (free_reg == '0 || lim == '0)
                            begin
                                status_next = STAT_NO_FREE;
                            end
                            else
                            begin
                                first_next  = '0;
                                lastm1_next = FRAME_IDX_W'(lim - 1'b1);
                                state_next  = ST_WALK;
                            end
                        end
                        FUNC_RELEASE:
                        begin
                            if (in_req.start_address[FRAME_SHIFT-1:0] != '0)
                            begin
                                status_next = STAT_MISALIGNED;
                            end
                            else if (f_rel >= FREL_W'(lim))
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                first_next  = f_rel[FRAME_IDX_W-1:0];
                                lastm1_next = f_rel[FRAME_IDX_W-1:0];
                                state_next  = ST_WALK;
                            end
                        end
                        default:
                        begin
                            if (FREL_W'(last_c) > f_rel)
                            begin
                                first_next  = f_rel[FRAME_IDX_W-1:0];
                                lastm1_next = FRAME_IDX_W'(last_c - 1'b1);
                                state_next  = ST_WALK;
                            end
                        end
                    endcase
                    issue_word_next = first_next[FRAME_IDX_W-1:BIT_IDX_W];
                    issue_more_next = 1'b1;
                end
            end
            ST_WALK:
            begin
                if (issue_more_reg)
                begin
                    ram_re          = 1'b1;
                    issue_word_next = issue_word_reg + 1'b1;
                    if (issue_word_reg == last_word)
                    begin
                        issue_more_next = 1'b0;
                    end
                end
                if (dv_reg)
                begin
                    case (op_reg)
                        FUNC_ALLOC:
                        begin
                            if (cand != '0)
                            begin
                                ram_we     = 1'b1;
                                ram_wdata  = ram_rdata | (cand & (~cand + 1'b1));
                                free_next  = free_reg - 1'b1;
                                addr_next  = ADDR_W'({data_word_reg, lowest_one(cand)})
                                           << FRAME_SHIFT;
                                state_next = ST_DONE;
                            end
                            else if (is_last)
                            begin
                                status_next = STAT_NO_FREE;
                                state_next  = ST_DONE;
                            end
                        end
                        FUNC_RELEASE:
                        begin
                            if ((ram_rdata & mask) == '0)
                            begin
                                status_next = STAT_DOUBLE_FREE;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = ram_rdata & ~mask;
                                free_next = (free_reg == '1) ? free_reg : free_reg + 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            ram_we          = 1'b1;
                            pend_valid_next = 1'b1;
                            pend_used_next  = (op_reg == FUNC_MARK_USED);
                            if (op_reg == FUNC_MARK_USED)
                            begin
                                ram_wdata   = ram_rdata | mask;
                                pend_n_next = pop_count(cand);
                            end
                            else
                            begin
                                ram_wdata   = ram_rdata & ~mask;
                                pend_n_next = pop_count(ram_rdata & mask);
                            end
                            if (is_last)
                            begin
                                state_next = ST_SETTLE;
                            end
                        end
                    endcase
                end
            end
            ST_SETTLE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next             = 1'b1;
                    out_rsp_next.frame_address = addr_reg;
                    out_rsp_next.status        = status_reg;
                    out_rsp_next.free_total    = free_reg;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            frame_count_reg <= FRAME_COUNT_RESET;
            free_reg        <= '0;
            clr_cnt_reg     <= '0;
            issue_more_reg  <= 1'b0;
            dv_reg          <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_reg       <= free_next;
            issue_more_reg <= issue_more_next;
            dv_reg         <= ram_re;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_write)
            begin
                frame_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        first_reg      <= first_next;
        lastm1_reg     <= lastm1_next;
        issue_word_reg <= issue_word_next;
        data_word_reg  <= issue_word_reg;
        pend_used_reg  <= pend_used_next;
        pend_n_reg     <= pend_n_next;
        status_reg     <= status_next;
        addr_reg       <= addr_next;
        out_rsp_reg    <= out_rsp_next;
    end

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (issue_word_reg),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_WALK))
        else $error("map write outside clear or walk");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && issue_more_reg) |-> (issue_word_reg <= last_word))
        else $error("map read beyond last word");

    a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && status_reg != STAT_OK) |-> (addr_reg == '0))
        else $error("failed request carries a frame address");

    a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && pend_used_reg) |=> (free_reg <= $past(free_reg)))
        else $error("free count grew while marking used");

endmodule
`default_nettype wire

// ===== tb/sv/bitmap_frame_allocator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_checker
// Watches the request, response and frame count ports of the frame allocator.
// Keeps its own used-bit map, free count and frame limit, works out the
// response owed for every accepted request and compares each accepted
// response, field by field, with the oldest one owed.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_checker (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_write,
    input  wire  [bfa_pkg::COUNT_W-1:0] cfg_data,
    input  wire                         in_valid,
    input  wire                         in_stall,
    input  wire  bfa_pkg::bfa_req_t     in_req,
    input  wire                         out_valid,
    input  wire                         out_stall,
    input  wire  bfa_pkg::bfa_rsp_t     out_rsp,
    output int                          fail_count,
    output int                          pending
);

    import bfa_pkg::*;

    logic [MAX_FRAMES-1:0] frame_used;
    logic [COUNT_W-1:0]    free_left;
    logic [COUNT_W-1:0]    frame_limit;
    bfa_rsp_t              owed_responses[$];
    bfa_rsp_t              owed;

    function automatic int unsigned usable_frames();
        return (frame_limit > MAX_FRAMES) ? MAX_FRAMES : int'(frame_limit);
    endfunction

    function automatic void walk_region(input logic [ADDR_W-1:0] base,
                                        input logic [LEN_W-1:0]  len,
                                        input logic              set_used);
        logic [63:0] first;
        logic [63:0] last;
        logic [63:0] f;
        first = 64'(base) >> FRAME_SHIFT;
        last  = (64'(base) + 64'(len) + 64'(FRAME_BYTES - 1)) >> FRAME_SHIFT;
        if (last > 64'(usable_frames()))
        begin
            last = 64'(usable_frames());
        end
        for (f = first; f < last; f++)
        begin
            if (set_used && !frame_used[f])
            begin
                frame_used[f] = 1'b1;
                if (free_left != '0)
                begin
                    free_left--;
                end
            end
            else if (!set_used && frame_used[f])
            begin
                frame_used[f] = 1'b0;
                if (free_left != '1)
                begin
                    free_left++;
                end
            end
        end
    endfunction

    function automatic bfa_rsp_t apply_request(input bfa_req_t req);
        bfa_rsp_t          rsp;
        int unsigned       lim;
        int unsigned       f;
        int unsigned       hit;
        logic              found;
        logic [ADDR_W-1:0] slot;
        rsp   = '0;
        lim   = usable_frames();
        found = 1'b0;
        hit   = 0;
        rsp.status = STAT_OK;
        case (req.func)
            FUNC_ALLOC:
            begin
                if (free_left != '0)
                begin
                    for (f = 0; f < lim; f++)
                    begin
                        if (!frame_used[f])
                        begin
                            hit   = f;
                            found = 1'b1;
                            break;
                        end
                    end
                end
                if (found)
                begin
                    frame_used[hit] = 1'b1;
                    free_left--;
                    rsp.frame_address = ADDR_W'(hit) << FRAME_SHIFT;
                end
                else
                begin
                    rsp.status = STAT_NO_FREE;
                end
            end
            FUNC_RELEASE:
            begin
                slot = req.start_address >> FRAME_SHIFT;
                if (req.start_address[FRAME_SHIFT-1:0] != '0)
                begin
                    rsp.status = STAT_MISALIGNED;
                end
                else if (slot >= lim)
                begin
                    rsp.status = STAT_RANGE;
                end
                else if (!frame_used[slot])
                begin
                    rsp.status = STAT_DOUBLE_FREE;
                end
                else
                begin
                    frame_used[slot] = 1'b0;
                    if (free_left != '1)
                    begin
                        free_left++;
                    end
                end
            end
            FUNC_MARK_USED:
            begin
                walk_region(req.start_address, req.region_length, 1'b1);
            end
            default:
            begin
                walk_region(req.start_address, req.region_length, 1'b0);
            end
        endcase
        rsp.free_total = free_left;
        return rsp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_used  = '1;
            free_left   = '0;
            frame_limit = FRAME_COUNT_RESET;
            owed_responses.delete();
            fail_count  = 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_write === 1'b1)
            begin
                frame_limit = cfg_data;
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
            begin
                owed_responses.push_back(apply_request(in_req));
            end
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (owed_responses.size() == 0)
                begin
                    $error("unrequested response: frame_address 0x%08h status %0d %s %0d",
                           out_rsp.frame_address, out_rsp.status, "free_total",
                           out_rsp.free_total);
                    fail_count++;
                end
                else
                begin
                    owed = owed_responses.pop_front();
                    if (out_rsp.frame_address !== owed.frame_address)
                    begin
                        $error("frame_address: expected 0x%08h, got 0x%08h",
                               owed.frame_address, out_rsp.frame_address);
                        fail_count++;
                    end
                    if (out_rsp.status !== owed.status)
                    begin
                        $error("status: expected %0d, got %0d", owed.status, out_rsp.status);
                        fail_count++;
                    end
                    if (out_rsp.free_total !== owed.free_total)
                    begin
                        $error("free_total: expected %0d, got %0d",
                               owed.free_total, out_rsp.free_total);
                        fail_count++;
                    end
                end
            end
            pending <= owed_responses.size();
        end
    end

endmodule

// ===== tb/sv/tb_bitmap_frame_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_frame_allocator
// Regression for the bitmap frame allocator. A directed run covers empty and
// full maps, every status code and clipped regions; random phases then run
// allocate, release and region requests under several frame counts, with
// random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_bitmap_frame_allocator;
    import bfa_pkg::*;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int MAX_GAP         = 18;
    localparam int SETTLE_CYCLES   = 1100;
    localparam int CYCLE_LIMIT     = 6_000_000;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [COUNT_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_stall;
    bfa_req_t           in_req;
    logic               out_valid;
    logic               out_stall;
    bfa_rsp_t           out_rsp;

    int                 fail_count;
    int                 pending;
    int                 cycle_count;
    int                 stall_left;
    int unsigned        frames_now;
    logic               quiet;

    logic [COUNT_W-1:0] phase_limits [PHASES] = '{
        16'd65535, 16'd0, 16'd1, 16'd0, 16'd37, 16'd32767,
        16'd300, 16'd0, 16'd32, 16'd32768, 16'd64, 16'd0
    };

    bitmap_frame_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp)
    );

    bitmap_frame_allocator_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_req     (in_req),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_rsp    (out_rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("bitmap_frame_allocator regression: fail");
            $finish;
        end
    end

    // after each taken response, draw a random stall for the next one (none when quiet)
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                stall_left = quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            else if (out_valid === 1'b1 && stall_left > 0)
            begin
                stall_left--;
            end
            out_stall <= (stall_left != 0);
        end
    end

    task automatic send_req(input bfa_req_t req);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge clk);
        while (in_stall !== 1'b0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_op(input logic [FUNC_W-1:0] func,
                           input logic [ADDR_W-1:0] addr,
                           input logic [LEN_W-1:0]  len);
        bfa_req_t req;
        req.func          = func;
        req.start_address = addr;
        req.region_length = len;
        send_req(req);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_frame_count(input logic [COUNT_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        frames_now = (value > MAX_FRAMES) ? MAX_FRAMES : int'(value);
    endtask

    task automatic send_random_request();
        int unsigned span;
        int unsigned frame;
        int unsigned pick;
        bfa_req_t    req;
        span  = (frames_now > 512) ? 512 : frames_now + 4;
        frame = $urandom_range(0, span - 1);
        pick  = $urandom_range(0, 99);
        req.start_address = $urandom();
        req.region_length = $urandom();
        if (pick < 35)
        begin
            req.func = FUNC_ALLOC;
        end
        else if (pick < 65)
        begin
            req.func = FUNC_RELEASE;
            case ($urandom_range(0, 9))
                0: req.start_address = (ADDR_W'(frame) << FRAME_SHIFT)
                                       | ADDR_W'($urandom_range(1, FRAME_BYTES - 1));
                1: req.start_address = $urandom();
                default: req.start_address = ADDR_W'(frame) << FRAME_SHIFT;
            endcase
        end
        else
        begin
            req.func = ($urandom_range(0, 99) < 55) ? FUNC_MARK_FREE : FUNC_MARK_USED;
            if (pick < 97)
            begin
                req.start_address = ADDR_W'(frame) << FRAME_SHIFT;
                if ($urandom_range(0, 1) == 1)
                begin
                    req.start_address += ADDR_W'($urandom_range(0, FRAME_BYTES - 1));
                end
                req.region_length = $urandom_range(0, 48 * FRAME_BYTES);
            end
        end
        send_req(req);
    endtask

    initial
    begin
        logic [COUNT_W-1:0] setting;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_req      = '0;
        out_stall   = 1'b0;
        cycle_count = 0;
        quiet       = 1'b0;
        frames_now  = MAX_FRAMES;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_op(FUNC_ALLOC,     32'h0000_0000, 32'h0000_0000);
        send_op(FUNC_RELEASE,   32'h0000_1234, 32'h0000_0000);
        send_op(FUNC_RELEASE,   32'hFFFF_F000, 32'hFFFF_FFFF);
        send_op(FUNC_RELEASE,   32'h0000_0000, 32'h0000_0000);
        send_op(FUNC_RELEASE,   32'h0000_0000, 32'h0000_0000);
        send_op(FUNC_MARK_FREE, 32'h0000_0000, 32'h0000_0000);
        send_op(FUNC_MARK_FREE, 32'h0000_0000, 32'h0002_0000);
        send_op(FUNC_ALLOC,     32'h0000_0000, 32'h0000_0000);
        send_op(FUNC_ALLOC,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(FUNC_RELEASE,   32'h0000_1000, 32'h0000_0000);
        send_op(FUNC_MARK_USED, 32'h0000_1001, 32'h0000_0001);
        send_op(FUNC_MARK_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(FUNC_MARK_FREE, 32'h07FF_8000, 32'hFFFF_FFFF);
        send_op(FUNC_RELEASE,   32'h0800_0000, 32'h0000_0000);
        send_op(FUNC_RELEASE,   32'h07FF_F000, 32'h0000_0000);
        send_op(FUNC_MARK_USED, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(FUNC_ALLOC,     32'h0000_0000, 32'h0000_0000);
        send_op(FUNC_MARK_FREE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(FUNC_ALLOC,     32'h0000_0000, 32'h0000_0000);
        send_op(FUNC_ALLOC,     32'h0000_0000, 32'h0000_0000);
        wait_idle();

        write_frame_count(16'd16);
        send_op(FUNC_MARK_USED, 32'h0000_0000, 32'h0001_0000);
        send_op(FUNC_ALLOC,     32'h0000_0000, 32'h0000_0000);
        send_op(FUNC_RELEASE,   32'h0001_0000, 32'h0000_0000);
        send_op(FUNC_MARK_FREE, 32'h0000_0000, 32'hFFFF_FFFF);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                3, 7, 11: setting = COUNT_W'($urandom_range(0, 65535));
                default:  setting = phase_limits[p];
            endcase
            write_frame_count(setting);
            quiet = (p % 4 == 2);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                send_random_request();
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("bitmap_frame_allocator regression: pass");
        end
        else
        begin
            $display("bitmap_frame_allocator regression: fail");
        end
        $finish;
    end

endmodule

// ===== bitmap_frame_allocator.f =====
rtl/bfa_pkg.sv
rtl/bfa_ram.sv
rtl/bitmap_frame_allocator.sv
tb/sv/bitmap_frame_allocator_checker.sv
tb/sv/tb_bitmap_frame_allocator.sv
